### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
		else $error("assertion failed");

// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/mmvn_pkg.sv
// ----------------------------------------------------------------------------
// mmvn_pkg
// Types and constants of the min/max value normalizer.
// ----------------------------------------------------------------------------
package mmvn_pkg;

	localparam int VAL_W   = 32;
	localparam int FLOOR_W = 31;
	localparam int QUOT_W  = 16;
	localparam int NORM_W  = 17;

	// Operation codes
	localparam logic [1:0] OP_UPDATE    = 2'd0;
	localparam logic [1:0] OP_NORMALIZE = 2'd1;
	localparam logic [1:0] OP_CLEAR     = 2'd2;

	localparam logic signed [VAL_W-1:0] Q_MOST_NEG = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] Q_MOST_POS = 32'sh7fff_ffff;
	localparam logic [NORM_W-1:0]       Q_ONE      = 17'h1_0000;

	// One statistics entry
	typedef struct packed {
		logic signed [VAL_W-1:0] high;
		logic signed [VAL_W-1:0] low;
	} stat_t;

	localparam stat_t STAT_EMPTY = '{high: Q_MOST_NEG, low: Q_MOST_POS};

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] numer;
		logic [VAL_W-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_PREP,
		S_DIV
	} state_t;

endpackage

### rtl/minmax_value_normalizer_core.sv
// ----------------------------------------------------------------------------
// minmax_value_normalizer_core
// Running min/max statistics table with fixed-point normalization.
// ----------------------------------------------------------------------------
// Usage: an operation is taken when start is high and busy is low; one
// operation is in flight at a time. Update, clear and the unused opcode hold
// busy in state EXEC (read, then write back on update and clear). Normalize
// also holds it in PREP, ending there if no division is needed (empty or
// zero-width range, value <= low, or >= high and >= low + delta_floor),
// then in DIV while the one-bit-per-cycle divider forms the 16-bit quotient;
// the result appears with done for exactly one cycle right after busy falls
// and is not held, so the receiver must take it then. After reset the table
// is swept to empty, one entry per cycle, keeping busy high; delta_floor may
// be written at any time the block is idle, including during the sweep.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module minmax_value_normalizer_core #(
	parameter int ENTRIES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [30:0]          cfg_wdata,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           opcode,
	input  logic [5:0]           entry_index,
	input  logic signed [31:0]   value,
	output logic                 done,
	output logic [16:0]          normalized
);

	localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int IDX_W = 13;

	logic                               accept;
	logic                               clearing;
	logic [IDX_W-1:0]                   idx_ext;
	logic [AW-1:0]                      rd_addr;
	mmvn_pkg::stat_t                    rd_data;
	logic                               wr_en;
	mmvn_pkg::stat_t                    wr_data;
	mmvn_pkg::div_req_t                 div_req;
	mmvn_pkg::div_rsp_t                 div_rsp;
	mmvn_pkg::state_t                   state_q;
	mmvn_pkg::state_t                   state_d;
	logic [mmvn_pkg::FLOOR_W-1:0]       delta_floor_q;
	logic [1:0]                         op_q;
	logic [AW-1:0]                      addr_q;
	logic                               hit_q;
	logic signed [mmvn_pkg::VAL_W-1:0]  val_q;
	logic signed [mmvn_pkg::VAL_W:0]    delta_q;
	logic signed [mmvn_pkg::VAL_W:0]    num_q;
	logic                               done_q;
	logic [mmvn_pkg::NORM_W-1:0]        norm_q;
	mmvn_pkg::stat_t                    cur;
	logic signed [mmvn_pkg::VAL_W:0]    delta_d;
	logic signed [mmvn_pkg::VAL_W:0]    num_d;
	logic signed [mmvn_pkg::VAL_W:0]    floor_ext;
	logic [mmvn_pkg::VAL_W-1:0]         divisor;
	logic                               out_now;
	logic [mmvn_pkg::NORM_W-1:0]        out_val;

	assign accept  = start & ~busy;
	assign busy    = (state_q != mmvn_pkg::S_IDLE) | clearing;
	assign idx_ext = {{(IDX_W - 6){1'b0}}, entry_index};
	assign rd_addr = idx_ext[AW-1:0];

	// Statistics table
	mmvn_stat_mem #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (addr_q),
		.wr_data  (wr_data),
		.clearing (clearing)
	);

	// Quotient unit
	mmvn_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_floor_q <= '0;
		end else if (cfg_we) begin
			delta_floor_q <= cfg_wdata;
		end
	end

	// State register and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmvn_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= out_now;
		end
	end

	// Capture the operation word and the working values
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			addr_q <= rd_addr;
			hit_q  <= (idx_ext < IDX_W'(ENTRIES));
			val_q  <= value;
		end
		if (state_q == mmvn_pkg::S_EXEC) begin
			delta_q <= delta_d;
			num_q   <= num_d;
		end
		if (out_now) begin
			norm_q <= out_val;
		end
	end

	// Entry as seen by normalize, range differences
	always_comb begin
		cur       = hit_q ? rd_data : mmvn_pkg::STAT_EMPTY;
		delta_d   = {cur.high[mmvn_pkg::VAL_W-1], cur.high}
		          - {cur.low[mmvn_pkg::VAL_W-1], cur.low};
		num_d     = {val_q[mmvn_pkg::VAL_W-1], val_q} - {cur.low[mmvn_pkg::VAL_W-1], cur.low};
		floor_ext = {2'b00, delta_floor_q};
		divisor   = (delta_q < floor_ext) ? {1'b0, delta_floor_q}
		                                  : delta_q[mmvn_pkg::VAL_W-1:0];
	end

	// Next state, write back, divider start and result
	always_comb begin
		state_d       = state_q;
		wr_en         = 1'b0;
		wr_data       = rd_data;
		div_req.start = 1'b0;
		div_req.numer = num_q[mmvn_pkg::VAL_W-1:0];
		div_req.denom = divisor;
		out_now       = 1'b0;
		out_val       = '0;
		case (state_q)
			mmvn_pkg::S_IDLE: begin
				if (accept) begin
					state_d = mmvn_pkg::S_EXEC;
				end
			end
			mmvn_pkg::S_EXEC: begin
				state_d = mmvn_pkg::S_IDLE;
				case (op_q)
					mmvn_pkg::OP_UPDATE: begin
						// widen the range
						wr_en = hit_q;
						wr_data.high = (val_q > rd_data.high) ? val_q : rd_data.high;
						wr_data.low  = (val_q < rd_data.low) ? val_q : rd_data.low;
					end
					mmvn_pkg::OP_CLEAR: begin
						wr_en   = hit_q;
						wr_data = mmvn_pkg::STAT_EMPTY;
					end
					mmvn_pkg::OP_NORMALIZE: begin
						state_d = mmvn_pkg::S_PREP;
					end
					default: begin
						state_d = mmvn_pkg::S_IDLE;
					end
				endcase
			end
			mmvn_pkg::S_PREP: begin
				state_d = mmvn_pkg::S_IDLE;
				if (delta_q[mmvn_pkg::VAL_W] || delta_q == '0) begin
					// empty, inverted or zero-width range: clamp the value itself
					out_now = 1'b1;
					if (val_q <= 0) begin
						out_val = '0;
					end else if (val_q >= $signed({15'd0, mmvn_pkg::Q_ONE})) begin
						out_val = mmvn_pkg::Q_ONE;
					end else begin
						out_val = val_q[mmvn_pkg::NORM_W-1:0];
					end
				end else if (num_q[mmvn_pkg::VAL_W] || num_q == '0) begin
					out_now = 1'b1;
					out_val = '0;
				end else if (num_q >= delta_q && num_q >= floor_ext) begin
					out_now = 1'b1;
					out_val = mmvn_pkg::Q_ONE;
				end else begin
					div_req.start = 1'b1;
					state_d       = mmvn_pkg::S_DIV;
				end
			end
			mmvn_pkg::S_DIV: begin
				if (div_rsp.done) begin
					out_now = 1'b1;
					out_val = {1'b0, div_rsp.quot};
					state_d = mmvn_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mmvn_pkg::S_IDLE;
			end
		endcase
	end

	assign done       = done_q;
	assign normalized = norm_q;

	// A result is a single-cycle strobe
	`ASSERT_NEXT(a_done_single, clk, arst_n, done_q, !done_q)
	// A result never exceeds one
	`ASSERT_IMPLIES(a_norm_range, clk, arst_n, done_q, norm_q <= mmvn_pkg::Q_ONE)
	// A result follows only a range check or a division
	`ASSERT_IMPLIES(a_done_src, clk, arst_n, done_q,
		$past(state_q) == mmvn_pkg::S_PREP || $past(state_q) == mmvn_pkg::S_DIV)
	// The divider runs only while waiting for it
	`ASSERT_IMPLIES(a_div_owned, clk, arst_n, div_rsp.busy, state_q == mmvn_pkg::S_DIV)
	// No write lands during the table sweep
	`ASSERT_IMPLIES(a_no_wr_clear, clk, arst_n, clearing, !wr_en && busy)

endmodule

### rtl/mmvn_stat_mem.sv
// ----------------------------------------------------------------------------
// mmvn_stat_mem
// Statistics table: one synchronous memory with a registered read port,
// swept to the empty entry value after reset.
// ----------------------------------------------------------------------------
module mmvn_stat_mem #(
	parameter int ENTRIES = 64,
	parameter int AW      = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output mmvn_pkg::stat_t    rd_data,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  mmvn_pkg::stat_t    wr_data,
	output logic               clearing
);

	mmvn_pkg::stat_t mem_q [ENTRIES];
	mmvn_pkg::stat_t rd_data_q;
	logic            clr_active_q;
	logic [AW-1:0]   clr_addr_q;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	mmvn_pkg::stat_t mem_wdata;

	// Sweep every entry once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == AW'(ENTRIES - 1)) begin
				clr_active_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Pick the sweep or the logic as writer
	always_comb begin
		mem_we    = clr_active_q | wr_en;
		mem_waddr = clr_active_q ? clr_addr_q : wr_addr;
		mem_wdata = clr_active_q ? mmvn_pkg::STAT_EMPTY : wr_data;
	end

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clr_active_q;

endmodule

### rtl/mmvn_divider.sv
// ----------------------------------------------------------------------------
// mmvn_divider
// Restoring divider, one quotient bit per cycle. Expects numer < denom and
// returns (numer << QUOT_W) / denom, truncated.
// ----------------------------------------------------------------------------
module mmvn_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  mmvn_pkg::div_req_t req,
	output mmvn_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(mmvn_pkg::QUOT_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [mmvn_pkg::VAL_W-1:0]    rem_q;
	logic [mmvn_pkg::VAL_W-1:0]    den_q;
	logic [mmvn_pkg::QUOT_W-1:0]   quot_q;
	logic [mmvn_pkg::VAL_W+1:0]    trial;
	logic                          fits;

	// Trial subtract of the doubled remainder
	always_comb begin
		trial = {1'b0, rem_q, 1'b0} - {2'b00, den_q};
		fits  = ~trial[mmvn_pkg::VAL_W+1];
	end

	// Control: count the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(mmvn_pkg::QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift in one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.numer;
			den_q  <= req.denom;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? trial[mmvn_pkg::VAL_W-1:0] : {rem_q[mmvn_pkg::VAL_W-2:0], 1'b0};
			quot_q <= {quot_q[mmvn_pkg::QUOT_W-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule
